// ===== src/assert_macros.svh =====
// Assertion helpers for the brc_checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define BRC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define BRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/brc_pkg.sv =====
// ---------------------------------------------------------------------------
// brc_pkg
// Types, constants and helpers for the binlog event range checker.
// ---------------------------------------------------------------------------
package brc_pkg;

  localparam int LENGTH_BITS_DEF = 32;
  localparam int CNT_BITS        = 28;

  localparam int HDR_BYTES = 19;
  localparam int SIZE_OFS  = 9;
  localparam int MAGIC_LEN = 4;
  localparam int FDE_OFS   = MAGIC_LEN + 4;

  localparam logic [7:0] FDE_TYPE = 8'h0f;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_LEN     = 3'd1;
  localparam logic [2:0] ERR_SHORT   = 3'd2;
  localparam logic [2:0] ERR_MAGIC   = 3'd3;
  localparam logic [2:0] ERR_NO_FDE  = 3'd4;
  localparam logic [2:0] ERR_PARTIAL = 3'd5;
  localparam logic [2:0] ERR_SIZE    = 3'd6;
  localparam logic [2:0] ERR_INEXACT = 3'd7;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first;
    logic        last;
    logic        at_file_start;
    logic [31:0] expected_length;
  } in_item_t;

  typedef struct packed {
    logic                range_ok;
    logic [2:0]          fault_code;
    logic [CNT_BITS-1:0] event_total;
  } out_item_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'hfe;
      2'd1:    b = 8'h62;
      2'd2:    b = 8'h69;
      default: b = 8'h6e;
    endcase
    return b;
  endfunction

endpackage

// ===== src/brc_frame.sv =====
// ---------------------------------------------------------------------------
// brc_frame
// Per-byte framing state: position, event boundaries, size capture,
// event count and first error. Produces the verdict for the current byte.
// ---------------------------------------------------------------------------
module brc_frame #(
  parameter int LENGTH_BITS = brc_pkg::LENGTH_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  brc_pkg::in_item_t  item,
  output brc_pkg::out_item_t verdict
);
  import brc_pkg::*;

  localparam int LB = LENGTH_BITS;
  localparam int CW = (LB > 32) ? LB : 32;
  localparam logic [LB-1:0] LEN_MAX = '1;

  logic [LB-1:0]       pos_r, pos_nxt;
  logic [LB-1:0]       nes_r, nes_nxt;
  logic [31:0]         acc_r, acc_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [2:0]          err_r, err_nxt;
  logic [LB-1:0]       len_r, len_nxt;
  logic                fs_r, fs_nxt;

  logic [LB-1:0]       pos_c, nes_c;
  logic [31:0]         acc_c;
  logic [CNT_BITS-1:0] cnt_c;
  logic [2:0]          err_c;
  logic [LB-1:0]       rel;
  logic [LB-1:0]       left_c;
  logic [CW-1:0]       room;
  logic [CW-1:0]       nes_sum;
  logic [31:0]         acc_w;
  logic [2:0]          code;

  always_comb begin
    if (item.first) begin
      pos_c   = '0;
      acc_c   = '0;
      cnt_c   = '0;
      err_c   = ERR_NONE;
      fs_nxt  = item.at_file_start;
      len_nxt = LB'(CW'(item.expected_length));
      nes_c   = item.at_file_start ? LB'(MAGIC_LEN) : '0;
    end else begin
      pos_c   = pos_r;
      acc_c   = acc_r;
      cnt_c   = cnt_r;
      err_c   = err_r;
      fs_nxt  = fs_r;
      len_nxt = len_r;
      nes_c   = nes_r;
    end

    pos_nxt = pos_c;
    nes_nxt = nes_c;
    acc_nxt = acc_c;
    cnt_nxt = cnt_c;
    err_nxt = err_c;

    rel     = pos_c - nes_c;
    left_c  = len_nxt - pos_c;
    room    = CW'(len_nxt - nes_c);
    acc_w   = acc_c;
    nes_sum = '0;

    if (pos_c == LEN_MAX) begin
      err_nxt = ERR_LEN;
    end else begin
      pos_nxt = pos_c + LB'(1);
      if (err_c == ERR_NONE && pos_c < len_nxt) begin
        if (fs_nxt && pos_c < LB'(MAGIC_LEN) &&
            item.data_byte != magic_byte(pos_c[1:0])) begin
          err_nxt = ERR_MAGIC;
        end else if (fs_nxt && pos_c == LB'(FDE_OFS) && item.data_byte != FDE_TYPE) begin
          err_nxt = ERR_NO_FDE;
        end else if (pos_c >= nes_c) begin
          if (rel == '0 && left_c < LB'(HDR_BYTES)) begin
            err_nxt = ERR_PARTIAL;
          end else begin
            if (rel == '0) begin
              acc_w = '0;
            end
            if (rel >= LB'(SIZE_OFS) && rel <= LB'(SIZE_OFS + 3)) begin
              case (rel[1:0])
                2'd1:    acc_w[7:0]   = item.data_byte;
                2'd2:    acc_w[15:8]  = item.data_byte;
                2'd3:    acc_w[23:16] = item.data_byte;
                default: acc_w[31:24] = item.data_byte;
              endcase
            end
            acc_nxt = acc_w;
            if (rel == LB'(SIZE_OFS + 3)) begin
              nes_sum = CW'(nes_c) + CW'(acc_w);
              if (acc_w < 32'(HDR_BYTES) || CW'(acc_w) > room) begin
                err_nxt = ERR_SIZE;
              end else begin
                nes_nxt = LB'(nes_sum);
                if (cnt_c != '1) begin
                  cnt_nxt = cnt_c + CNT_BITS'(1);
                end
              end
            end
          end
        end
      end
    end

    if (len_nxt == '0 || pos_nxt != len_nxt || err_nxt == ERR_LEN) begin
      code = ERR_LEN;
    end else if (fs_nxt && len_nxt < LB'(MAGIC_LEN + HDR_BYTES)) begin
      code = ERR_SHORT;
    end else if (err_nxt != ERR_NONE) begin
      code = err_nxt;
    end else if (cnt_nxt == '0) begin
      code = ERR_INEXACT;
    end else begin
      code = ERR_NONE;
    end

    verdict.range_ok    = (code == ERR_NONE);
    verdict.fault_code  = code;
    verdict.event_total = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      nes_r <= '0;
      acc_r <= '0;
      cnt_r <= '0;
      err_r <= ERR_NONE;
      len_r <= '0;
      fs_r  <= 1'b0;
    end else if (step) begin
      pos_r <= pos_nxt;
      nes_r <= nes_nxt;
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
      err_r <= err_nxt;
      len_r <= len_nxt;
      fs_r  <= fs_nxt;
    end
  end

endmodule

// ===== src/binlog_event_range_checker_core.sv =====
// A range's last byte is held in the input register in_r; its verdict is then registered in out_r.
// Throughput: one byte per cycle unless stalled; the framing state updates once per byte.
// A pending verdict stalls the input only when the next last byte arrives.
// Reset (rst_n low, synchronous) clears all framing state and the valid flags of both stages.
// ---------------------------------------------------------------------------
// binlog_event_range_checker_core
// Checks event framing of one binlog range streamed byte by byte and
// reports a verdict with the event count on the range's last byte.
// ---------------------------------------------------------------------------
module binlog_event_range_checker_core #(
  parameter int LENGTH_BITS = brc_pkg::LENGTH_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  brc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output brc_pkg::out_item_t out_data
);
  import brc_pkg::*;

  in_item_t  in_r;
  logic      in_vld_r;
  out_item_t out_r;
  logic      out_vld_r;
  out_item_t verdict;
  logic      blocked;
  logic      step;

  assign blocked  = in_vld_r && in_r.last && out_vld_r && !out_ready;
  assign step     = in_vld_r && !blocked;
  assign in_ready = !in_vld_r || !blocked;

  brc_frame #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_frame (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_r),
    .verdict(verdict)
  );

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (step && in_r.last) begin
      out_r <= verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_vld_r <= 1'b1;
      end else if (step) begin
        in_vld_r <= 1'b0;
      end
      if (step && in_r.last) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// ===== src/brc_checker.sv =====
// ---------------------------------------------------------------------------
// brc_checker
// Port-level checks on the range checker, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module brc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input brc_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input brc_pkg::out_item_t out_data
);
  import brc_pkg::*;

  `BRC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                   out_valid && $stable(out_data))
  `BRC_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready,
                   in_valid && $stable(in_data))
  `BRC_ASSERT_NOW(a_ok_matches_code, clk, rst_n, out_valid,
                  out_data.range_ok == (out_data.fault_code == ERR_NONE))
  `BRC_ASSERT_NOW(a_ok_has_events, clk, rst_n, out_valid && out_data.range_ok,
                  out_data.event_total != '0)
  `BRC_ASSERT_NOW(a_stall_only_on_verdict, clk, rst_n, !in_ready,
                  out_valid)

endmodule

bind binlog_event_range_checker_core brc_checker u_brc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
